@@ hdl/tgpw_pkg.sv @@
// Shared types, register indexes, character codes and the 8x8 font table.
`default_nettype none
package tgpw_pkg;

	localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
	localparam logic [2:0] REG_CLIP_WIDTH  = 3'd2;
	localparam logic [2:0] REG_CLIP_HEIGHT = 3'd3;
	localparam logic [2:0] REG_ROW_PITCH   = 3'd4;
	localparam logic [2:0] REG_FRAME_BASE  = 3'd5;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_FIRST   = 8'd32;
	localparam logic [7:0] CODE_LAST    = 8'd127;
	localparam logic [7:0] CODE_SUBST   = 8'd63;

	localparam logic [15:0] LINE_ADVANCE = 16'd9;
	localparam logic [15:0] CHAR_ADVANCE = 16'd8;

	localparam logic [7:0] FONT_ROM [0:95][0:7] = '{
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h18,8'h18,8'h18,8'h18,8'h00,8'h00,8'h18,8'h00},
		'{8'h36,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h36,8'h36,8'h7f,8'h36,8'h7f,8'h36,8'h36,8'h00},
		'{8'h0c,8'h3e,8'h03,8'h1e,8'h30,8'h1f,8'h0c,8'h00},
		'{8'h00,8'h63,8'h33,8'h18,8'h0c,8'h66,8'h63,8'h00},
		'{8'h1c,8'h36,8'h1c,8'h6e,8'h3b,8'h33,8'h6e,8'h00},
		'{8'h06,8'h06,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h18,8'h0c,8'h06,8'h06,8'h06,8'h0c,8'h18,8'h00},
		'{8'h06,8'h0c,8'h18,8'h18,8'h18,8'h0c,8'h06,8'h00},
		'{8'h00,8'h66,8'h3c,8'hff,8'h3c,8'h66,8'h00,8'h00},
		'{8'h00,8'h0c,8'h0c,8'h3f,8'h0c,8'h0c,8'h00,8'h00},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0c,8'h0c,8'h06},
		'{8'h00,8'h00,8'h00,8'h3f,8'h00,8'h00,8'h00,8'h00},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0c,8'h0c,8'h00},
		'{8'h60,8'h30,8'h18,8'h0c,8'h06,8'h03,8'h01,8'h00},
		'{8'h1e,8'h33,8'h3b,8'h37,8'h33,8'h33,8'h1e,8'h00},
		'{8'h0c,8'h0e,8'h0c,8'h0c,8'h0c,8'h0c,8'h3f,8'h00},
		'{8'h1e,8'h33,8'h30,8'h1c,8'h06,8'h33,8'h3f,8'h00},
		'{8'h1e,8'h33,8'h30,8'h1c,8'h30,8'h33,8'h1e,8'h00},
		'{8'h38,8'h3c,8'h36,8'h33,8'h7f,8'h30,8'h78,8'h00},
		'{8'h3f,8'h03,8'h1f,8'h30,8'h30,8'h33,8'h1e,8'h00},
		'{8'h1c,8'h06,8'h03,8'h1f,8'h33,8'h33,8'h1e,8'h00},
		'{8'h3f,8'h33,8'h30,8'h18,8'h0c,8'h0c,8'h0c,8'h00},
		'{8'h1e,8'h33,8'h33,8'h1e,8'h33,8'h33,8'h1e,8'h00},
		'{8'h1e,8'h33,8'h33,8'h3e,8'h30,8'h18,8'h0e,8'h00},
		'{8'h00,8'h0c,8'h0c,8'h00,8'h00,8'h0c,8'h0c,8'h00},
		'{8'h00,8'h0c,8'h0c,8'h00,8'h00,8'h0c,8'h0c,8'h06},
		'{8'h18,8'h0c,8'h06,8'h03,8'h06,8'h0c,8'h18,8'h00},
		'{8'h00,8'h00,8'h3f,8'h00,8'h00,8'h3f,8'h00,8'h00},
		'{8'h06,8'h0c,8'h18,8'h30,8'h18,8'h0c,8'h06,8'h00},
		'{8'h1e,8'h33,8'h30,8'h18,8'h0c,8'h00,8'h0c,8'h00},
		'{8'h3e,8'h63,8'h7b,8'h7b,8'h7b,8'h03,8'h1e,8'h00},
		'{8'h0c,8'h1e,8'h33,8'h33,8'h3f,8'h33,8'h33,8'h00},
		'{8'h3f,8'h66,8'h66,8'h3e,8'h66,8'h66,8'h3f,8'h00},
		'{8'h3c,8'h66,8'h03,8'h03,8'h03,8'h66,8'h3c,8'h00},
		'{8'h1f,8'h36,8'h66,8'h66,8'h66,8'h36,8'h1f,8'h00},
		'{8'h7f,8'h46,8'h16,8'h1e,8'h16,8'h46,8'h7f,8'h00},
		'{8'h7f,8'h46,8'h16,8'h1e,8'h16,8'h06,8'h0f,8'h00},
		'{8'h3c,8'h66,8'h03,8'h03,8'h73,8'h66,8'h7c,8'h00},
		'{8'h33,8'h33,8'h33,8'h3f,8'h33,8'h33,8'h33,8'h00},
		'{8'h1e,8'h0c,8'h0c,8'h0c,8'h0c,8'h0c,8'h1e,8'h00},
		'{8'h78,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1e,8'h00},
		'{8'h67,8'h66,8'h36,8'h1e,8'h36,8'h66,8'h67,8'h00},
		'{8'h0f,8'h06,8'h06,8'h06,8'h46,8'h66,8'h7f,8'h00},
		'{8'h63,8'h77,8'h7f,8'h7f,8'h6b,8'h63,8'h63,8'h00},
		'{8'h63,8'h67,8'h6f,8'h7b,8'h73,8'h63,8'h63,8'h00},
		'{8'h1c,8'h36,8'h63,8'h63,8'h63,8'h36,8'h1c,8'h00},
		'{8'h3f,8'h66,8'h66,8'h3e,8'h06,8'h06,8'h0f,8'h00},
		'{8'h1e,8'h33,8'h33,8'h33,8'h3b,8'h1e,8'h38,8'h00},
		'{8'h3f,8'h66,8'h66,8'h3e,8'h36,8'h66,8'h67,8'h00},
		'{8'h1e,8'h33,8'h07,8'h0e,8'h38,8'h33,8'h1e,8'h00},
		'{8'h3f,8'h2d,8'h0c,8'h0c,8'h0c,8'h0c,8'h1e,8'h00},
		'{8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h3f,8'h00},
		'{8'h33,8'h33,8'h33,8'h33,8'h33,8'h1e,8'h0c,8'h00},
		'{8'h63,8'h63,8'h63,8'h6b,8'h7f,8'h77,8'h63,8'h00},
		'{8'h63,8'h63,8'h36,8'h1c,8'h1c,8'h36,8'h63,8'h00},
		'{8'h33,8'h33,8'h33,8'h1e,8'h0c,8'h0c,8'h1e,8'h00},
		'{8'h7f,8'h63,8'h31,8'h18,8'h4c,8'h66,8'h7f,8'h00},
		'{8'h1e,8'h06,8'h06,8'h06,8'h06,8'h06,8'h1e,8'h00},
		'{8'h03,8'h06,8'h0c,8'h18,8'h30,8'h60,8'h40,8'h00},
		'{8'h1e,8'h18,8'h18,8'h18,8'h18,8'h18,8'h1e,8'h00},
		'{8'h08,8'h1c,8'h36,8'h63,8'h00,8'h00,8'h00,8'h00},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hff},
		'{8'h0c,8'h0c,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h00,8'h00,8'h1e,8'h30,8'h3e,8'h33,8'h6e,8'h00},
		'{8'h07,8'h06,8'h06,8'h3e,8'h66,8'h66,8'h3b,8'h00},
		'{8'h00,8'h00,8'h1e,8'h33,8'h03,8'h33,8'h1e,8'h00},
		'{8'h38,8'h30,8'h30,8'h3e,8'h33,8'h33,8'h6e,8'h00},
		'{8'h00,8'h00,8'h1e,8'h33,8'h3f,8'h03,8'h1e,8'h00},
		'{8'h1c,8'h36,8'h06,8'h0f,8'h06,8'h06,8'h0f,8'h00},
		'{8'h00,8'h00,8'h6e,8'h33,8'h33,8'h3e,8'h30,8'h1f},
		'{8'h07,8'h06,8'h36,8'h6e,8'h66,8'h66,8'h67,8'h00},
		'{8'h0c,8'h00,8'h0e,8'h0c,8'h0c,8'h0c,8'h1e,8'h00},
		'{8'h30,8'h00,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1e},
		'{8'h07,8'h06,8'h66,8'h36,8'h1e,8'h36,8'h67,8'h00},
		'{8'h0e,8'h0c,8'h0c,8'h0c,8'h0c,8'h0c,8'h1e,8'h00},
		'{8'h00,8'h00,8'h33,8'h7f,8'h7f,8'h6b,8'h63,8'h00},
		'{8'h00,8'h00,8'h1f,8'h33,8'h33,8'h33,8'h33,8'h00},
		'{8'h00,8'h00,8'h1e,8'h33,8'h33,8'h33,8'h1e,8'h00},
		'{8'h00,8'h00,8'h3b,8'h66,8'h66,8'h3e,8'h06,8'h0f},
		'{8'h00,8'h00,8'h6e,8'h33,8'h33,8'h3e,8'h30,8'h78},
		'{8'h00,8'h00,8'h3b,8'h6e,8'h66,8'h06,8'h0f,8'h00},
		'{8'h00,8'h00,8'h3e,8'h03,8'h1e,8'h30,8'h1f,8'h00},
		'{8'h08,8'h0c,8'h3e,8'h0c,8'h0c,8'h2c,8'h18,8'h00},
		'{8'h00,8'h00,8'h33,8'h33,8'h33,8'h33,8'h6e,8'h00},
		'{8'h00,8'h00,8'h33,8'h33,8'h33,8'h1e,8'h0c,8'h00},
		'{8'h00,8'h00,8'h63,8'h6b,8'h7f,8'h7f,8'h36,8'h00},
		'{8'h00,8'h00,8'h63,8'h36,8'h1c,8'h36,8'h63,8'h00},
		'{8'h00,8'h00,8'h33,8'h33,8'h33,8'h3e,8'h30,8'h1f},
		'{8'h00,8'h00,8'h3f,8'h19,8'h0c,8'h26,8'h3f,8'h00},
		'{8'h38,8'h0c,8'h0c,8'h07,8'h0c,8'h0c,8'h38,8'h00},
		'{8'h18,8'h18,8'h18,8'h00,8'h18,8'h18,8'h18,8'h00},
		'{8'h07,8'h0c,8'h0c,8'h38,8'h0c,8'h0c,8'h07,8'h00},
		'{8'h6e,8'h3b,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff}
	};

	typedef struct packed {
		logic [15:0] line_col;
		logic [15:0] row;
		logic [15:0] col;
	} cursor_t;

	typedef struct packed {
		logic [15:0] col;
		logic [15:0] row;
		logic [7:0]  col_mask;
		logic [7:0]  row_mask;
		logic [2:0]  last_col;
		logic [2:0]  last_row;
		logic [63:0] glyph;
		logic [31:0] fg;
		logic [31:0] bg;
	} char_job_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] colour;
		logic        last;
	} pixel_t;

	// glyph bit (row * 8 + col), bit 0 of each row is the leftmost column
	function automatic logic [63:0] glyph_bits(input logic [7:0] code);
		logic [6:0]  idx;
		logic [63:0] bits;
		if (code inside {[CODE_FIRST:CODE_LAST]}) begin
			idx = 7'(code - CODE_FIRST);
		end else begin
			idx = 7'(CODE_SUBST - CODE_FIRST);
		end
		for (int r = 0; r < 8; r++) begin
			bits[r*8 +: 8] = FONT_ROM[idx][r];
		end
		return bits;
	endfunction

	function automatic logic [2:0] top_bit(input logic [7:0] mask);
		logic [2:0] pos;
		pos = '0;
		for (int i = 0; i < 8; i++) begin
			if (mask[i]) begin
				pos = 3'(i);
			end
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

@@ hdl/tgpw_ram.sv @@
// Generic single-write, registered-read RAM.
`default_nettype none
module tgpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/tgpw_scan.sv @@
// Glyph cell scanner: walks the 64 cells of one character, one cell per cycle while adv is high.
`default_nettype none
module tgpw_scan
	import tgpw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire char_job_t job,
	input  wire logic      adv,
	output logic           ready,
	output logic           pix_valid,
	output pixel_t         pix
);

	logic      busy_q;
	logic [5:0] cell_q;
	char_job_t job_q;
	logic      pix_valid_s2;
	pixel_t    pix_s2;

	logic [2:0] r;
	logic [2:0] c;
	logic       finish;
	logic       hit;

	assign r      = cell_q[5:3];
	assign c      = cell_q[2:0];
	assign finish = busy_q && adv && (&cell_q);
	assign ready  = !busy_q || finish;
	assign hit    = job_q.row_mask[r] && job_q.col_mask[c];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cell_q       <= '0;
			pix_valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cell_q <= '0;
			end else if (busy_q && adv) begin
				cell_q <= cell_q + 6'd1;
				if (&cell_q) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				pix_valid_s2 <= busy_q && hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
		if (adv) begin
			pix_s2.x      <= job_q.col + {13'd0, c};
			pix_s2.y      <= job_q.row + {13'd0, r};
			pix_s2.colour <= job_q.glyph[cell_q] ? job_q.fg : job_q.bg;
			pix_s2.last   <= (r == job_q.last_row) && (c == job_q.last_col);
		end
	end

	assign pix_valid = pix_valid_s2;
	assign pix       = pix_s2;

	a_load_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("scanner loaded while still walking a glyph");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && (cell_q == 6'd0))
		else $error("scanner did not restart at cell zero");

endmodule
`default_nettype wire

@@ hdl/text_glyph_pixel_writer.sv @@
// Top level: text cursor, 8x8 glyph scan with clipping and pixel address generation.
//
//  channel   dir  handshake                   payload
//  char      in   char_valid / char_stall     char_code fg_colour bg_colour new_string
//                                             start_x start_y
//  pixel     out  pixel_valid / pixel_stall   pixel_x pixel_y pixel_colour pixel_address
//                                             last_of_char
//  cfg       in   cfg_write                   cfg_index cfg_data
//
//  A visible glyph holds the scanner while its cell counter walks the 64 cells, one cell per
//  cycle while adv is high; the first pixel passes the input stage, the scanner's job and
//  pixel registers and address stages s3, s4. Newlines and fully clipped characters retire
//  in the input stage. Cursor state lives in entry zero of a two-entry RAM, forwarded on
//  back-to-back updates; a valid bit stands in for its reset value, so no clearing pass is needed.
//  pixel_stall freezes the scanner and address pipeline while pixel_valid is high; char_stall
//  is raised while the input stage holds a glyph the scanner cannot take yet.
`default_nettype none
module text_glyph_pixel_writer
	import tgpw_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 768
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               char_valid,
	output logic                    char_stall,
	input  wire logic [7:0]         char_code,
	input  wire logic [31:0]        fg_colour,
	input  wire logic [31:0]        bg_colour,
	input  wire logic               new_string,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	output logic                    pixel_valid,
	input  wire logic               pixel_stall,
	output logic signed [15:0]      pixel_x,
	output logic signed [15:0]      pixel_y,
	output logic [31:0]             pixel_colour,
	output logic [31:0]             pixel_address,
	output logic                    last_of_char
);

	localparam int         STATE_DEPTH = 2;
	localparam logic       CUR_ADDR    = 1'b0;
	localparam logic [14:0] RST_WIDTH  = 15'(SCREEN_WIDTH);
	localparam logic [14:0] RST_HEIGHT = 15'(SCREEN_HEIGHT);

	// configuration
	logic signed [15:0] clip_left_q;
	logic signed [15:0] clip_top_q;
	logic [14:0]        clip_width_q;
	logic [14:0]        clip_height_q;
	logic signed [16:0] clip_right_q;
	logic signed [16:0] clip_bottom_q;
	logic [15:0]        row_pitch_q;
	logic [31:0]        frame_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_width_q  <= RST_WIDTH;
			clip_height_q <= RST_HEIGHT;
			clip_right_q  <= $signed({2'b00, RST_WIDTH});
			clip_bottom_q <= $signed({2'b00, RST_HEIGHT});
			row_pitch_q   <= 16'd4096;
			frame_base_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CLIP_LEFT: begin
					clip_left_q  <= $signed(cfg_data[15:0]);
					clip_right_q <= $signed({cfg_data[15], cfg_data[15:0]})
						+ $signed({2'b00, clip_width_q});
				end
				REG_CLIP_TOP: begin
					clip_top_q    <= $signed(cfg_data[15:0]);
					clip_bottom_q <= $signed({cfg_data[15], cfg_data[15:0]})
						+ $signed({2'b00, clip_height_q});
				end
				REG_CLIP_WIDTH: begin
					clip_width_q <= cfg_data[14:0];
					clip_right_q <= $signed({clip_left_q[15], clip_left_q})
						+ $signed({2'b00, cfg_data[14:0]});
				end
				REG_CLIP_HEIGHT: begin
					clip_height_q <= cfg_data[14:0];
					clip_bottom_q <= $signed({clip_top_q[15], clip_top_q})
						+ $signed({2'b00, cfg_data[14:0]});
				end
				REG_ROW_PITCH: begin
					row_pitch_q <= cfg_data[15:0];
				end
				REG_FRAME_BASE: begin
					frame_base_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// input stage
	logic        char_valid_s1;
	logic [7:0]  code_s1;
	logic [31:0] fg_s1;
	logic [31:0] bg_s1;
	logic        new_s1;
	logic [15:0] sx_s1;
	logic [15:0] sy_s1;

	logic      accept;
	logic      consume;
	logic      scan_load;
	logic      scan_ready;
	logic      is_nl;
	logic      visible;
	logic      adv;

	// cursor store
	cursor_t ram_rdata;
	cursor_t ram_wdata;
	cursor_t fwd_data_q;
	cursor_t cur;
	logic    ram_we;
	logic    written_q;
	logic    fwd_q;

	tgpw_ram #(
		.WIDTH ($bits(cursor_t)),
		.DEPTH (STATE_DEPTH)
	) u_cursor_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (CUR_ADDR),
		.wdata (ram_wdata),
		.raddr (CUR_ADDR),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= 1'b0;
			fwd_q     <= 1'b0;
		end else begin
			fwd_q <= ram_we;
			if (ram_we) begin
				written_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_data_q <= ram_wdata;
		end
	end

	assign cur = !written_q ? '0 : (fwd_q ? fwd_data_q : ram_rdata);

	logic [15:0] base_col;
	logic [15:0] base_row;
	logic [15:0] line_col;
	logic [7:0]  col_mask;
	logic [7:0]  row_mask;
	char_job_t   job;

	assign base_col = new_s1 ? sx_s1 : cur.col;
	assign base_row = new_s1 ? sy_s1 : cur.row;
	assign line_col = new_s1 ? sx_s1 : cur.line_col;
	assign is_nl    = (code_s1 == CODE_NEWLINE);

	always_comb begin
		logic [15:0] xi;
		logic [15:0] yi;
		col_mask = '0;
		row_mask = '0;
		for (int i = 0; i < 8; i++) begin
			xi = base_col + 16'(i);
			yi = base_row + 16'(i);
			col_mask[i] = ($signed(xi) >= clip_left_q)
				&& ($signed({xi[15], xi}) < clip_right_q);
			row_mask[i] = ($signed(yi) >= clip_top_q)
				&& ($signed({yi[15], yi}) < clip_bottom_q);
		end
	end

	assign visible = (|col_mask) && (|row_mask);

	always_comb begin
		job.col      = base_col;
		job.row      = base_row;
		job.col_mask = col_mask;
		job.row_mask = row_mask;
		job.last_col = top_bit(col_mask);
		job.last_row = top_bit(row_mask);
		job.glyph    = glyph_bits(code_s1);
		job.fg       = fg_s1;
		job.bg       = bg_s1;
	end

	assign consume    = char_valid_s1 && (is_nl || !visible || scan_ready);
	assign scan_load  = char_valid_s1 && !is_nl && visible && scan_ready;
	assign char_stall = char_valid_s1 && !consume;
	assign accept     = char_valid && !char_stall;
	assign ram_we     = consume;

	always_comb begin
		ram_wdata.line_col = line_col;
		if (is_nl) begin
			ram_wdata.row = base_row + LINE_ADVANCE;
			ram_wdata.col = line_col;
		end else begin
			ram_wdata.row = base_row;
			ram_wdata.col = base_col + CHAR_ADVANCE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
		end else if (accept) begin
			char_valid_s1 <= 1'b1;
		end else if (consume) begin
			char_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1 <= char_code;
			fg_s1   <= fg_colour;
			bg_s1   <= bg_colour;
			new_s1  <= new_string;
			sx_s1   <= start_x;
			sy_s1   <= start_y;
		end
	end

	// cell scan
	logic   pix_valid_s2;
	pixel_t pix_s2;

	tgpw_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (scan_load),
		.job       (job),
		.adv       (adv),
		.ready     (scan_ready),
		.pix_valid (pix_valid_s2),
		.pix       (pix_s2)
	);

	// address pipeline
	logic               valid_s3;
	pixel_t             pix_s3;
	logic [31:0]        yprod_s3;
	logic signed [33:0] yprod;
	logic               valid_s4;
	pixel_t             pix_s4;
	logic [31:0]        addr_s4;

	assign adv   = !valid_s4 || !pixel_stall;
	assign yprod = $signed({pix_s2.y[15], pix_s2.y}) * $signed({1'b0, row_pitch_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= pix_valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s3   <= pix_s2;
			yprod_s3 <= yprod[31:0];
			pix_s4   <= pix_s3;
			addr_s4  <= frame_base_q + yprod_s3
				+ {{14{pix_s3.x[15]}}, pix_s3.x, 2'b00};
		end
	end

	assign pixel_valid   = valid_s4;
	assign pixel_x       = $signed(pix_s4.x);
	assign pixel_y       = $signed(pix_s4.y);
	assign pixel_colour  = pix_s4.colour;
	assign pixel_address = addr_s4;
	assign last_of_char  = pix_s4.last;

	a_cursor_forward: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (cur == $past(ram_wdata)))
		else $error("cursor update not seen on the following cycle");

	a_input_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && char_valid_s1) |-> consume)
		else $error("request taken over an input stage that is not draining");

	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && adv) |=> pixel_valid)
		else $error("pixel lost between address stages");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for text_glyph_pixel_writer: feeds characters and checks every pixel write.
module tb_top;
	import tgpw_pkg::*;

	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [7:0]  code;
		logic [31:0] fg;
		logic [31:0] bg;
		logic        restart;
		logic [15:0] sx;
		logic [15:0] sy;
	} char_req_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] colour;
		logic [31:0] address;
		logic        last;
	} pixel_exp_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               char_valid;
	logic               char_stall;
	logic [7:0]         char_code;
	logic [31:0]        fg_colour;
	logic [31:0]        bg_colour;
	logic               new_string;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic               pixel_valid;
	logic               pixel_stall;
	logic signed [15:0] pixel_x;
	logic signed [15:0] pixel_y;
	logic [31:0]        pixel_colour;
	logic [31:0]        pixel_address;
	logic               last_of_char;

	text_glyph_pixel_writer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.char_valid(char_valid), .char_stall(char_stall), .char_code(char_code),
		.fg_colour(fg_colour), .bg_colour(bg_colour), .new_string(new_string),
		.start_x(start_x), .start_y(start_y),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel_x(pixel_x),
		.pixel_y(pixel_y), .pixel_colour(pixel_colour), .pixel_address(pixel_address),
		.last_of_char(last_of_char)
	);

	// predictor copy of the registers and the cursor
	logic [15:0] win_left, win_top, pitch;
	logic [14:0] win_w, win_h;
	logic [31:0] fb_base;
	logic [15:0] cur_col, cur_row, margin_col;

	pixel_exp_t pixels_due [$];
	pixel_exp_t head_pixel;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int chars_sent     = 0;
	int pixels_checked = 0;
	int settings_used  = 0;
	int quiet_cycles   = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic char_req_t mk(input logic [7:0] code, input logic [31:0] fg,
			input logic [31:0] bg, input logic restart, input logic [15:0] sx,
			input logic [15:0] sy);
		char_req_t rq;
		rq.code = code;
		rq.fg = fg;
		rq.bg = bg;
		rq.restart = restart;
		rq.sx = sx;
		rq.sy = sy;
		return rq;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("MISMATCH: %s", msg);
		end
	endfunction

	task automatic predict_glyph_pixels(input char_req_t rq);
		logic [7:0]  code, bits;
		logic [15:0] px, py;
		logic [31:0] xext, yext;
		int          xi, yi, left_i, top_i, right_i, bottom_i, n, r, c;
		pixel_exp_t  found [64];
		if (rq.restart) begin
			cur_col = rq.sx;
			cur_row = rq.sy;
			margin_col = rq.sx;
		end
		if (rq.code == CODE_NEWLINE) begin
			cur_col = margin_col;
			cur_row = cur_row + LINE_ADVANCE;
			return;
		end
		code = (rq.code < CODE_FIRST || rq.code > CODE_LAST) ? CODE_SUBST : rq.code;
		left_i = $signed(win_left);
		top_i = $signed(win_top);
		right_i = left_i + int'(win_w);
		bottom_i = top_i + int'(win_h);
		n = 0;
		for (r = 0; r < 8; r++) begin
			bits = FONT_ROM[code - CODE_FIRST][r];
			py = cur_row + r;
			yi = $signed(py);
			for (c = 0; c < 8; c++) begin
				px = cur_col + c;
				xi = $signed(px);
				if (xi >= left_i && xi < right_i && yi >= top_i && yi < bottom_i) begin
					xext = {{16{px[15]}}, px};
					yext = {{16{py[15]}}, py};
					found[n].x = px;
					found[n].y = py;
					found[n].colour = bits[c] ? rq.fg : rq.bg;
					found[n].address = fb_base + yext * {16'd0, pitch} + {xext[29:0], 2'b00};
					found[n].last = 1'b0;
					n++;
				end
			end
		end
		for (r = 0; r < n; r++) begin
			found[r].last = (r == n - 1);
			pixels_due.push_back(found[r]);
		end
		cur_col = cur_col + CHAR_ADVANCE;
	endtask

	task automatic send_char(input char_req_t rq);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			char_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		char_valid <= 1'b1;
		char_code <= rq.code;
		fg_colour <= rq.fg;
		bg_colour <= rq.bg;
		new_string <= rq.restart;
		start_x <= rq.sx;
		start_y <= rq.sy;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		predict_glyph_pixels(rq);
		chars_sent++;
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		char_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_CLIP_LEFT:   win_left = value[15:0];
			REG_CLIP_TOP:    win_top = value[15:0];
			REG_CLIP_WIDTH:  win_w = value[14:0];
			REG_CLIP_HEIGHT: win_h = value[14:0];
			REG_ROW_PITCH:   pitch = value[15:0];
			REG_FRAME_BASE:  fb_base = value;
			default: ;
		endcase
	endtask

	// unused upper bits of every write but the frame base carry noise
	task automatic apply_window(input logic [15:0] left, input logic [15:0] top,
			input logic [14:0] w, input logic [14:0] h, input logic [15:0] row_pitch,
			input logic [31:0] base);
		logic [31:0] junk;
		junk = $urandom;
		set_reg(REG_CLIP_LEFT, {junk[31:16], left});
		set_reg(REG_CLIP_TOP, {junk[15:0], top});
		junk = $urandom;
		set_reg(REG_CLIP_WIDTH, {junk[31:15], w});
		set_reg(REG_CLIP_HEIGHT, {junk[16:0], h});
		junk = $urandom;
		set_reg(REG_ROW_PITCH, {junk[31:16], row_pitch});
		set_reg(REG_FRAME_BASE, base);
		settings_used++;
	endtask

	task automatic test_reset_cursor();
		send_char(mk(8'h41, 32'h0, 32'hffff_ffff, 1'b0, 16'h0, 16'h0));
		send_char(mk(CODE_LAST, 32'hffff_ffff, 32'h0, 1'b0, 16'h0, 16'h0));
		send_char(mk(CODE_NEWLINE, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		send_char(mk(8'h00, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		send_char(mk(8'hff, $urandom, $urandom, 1'b0, 16'hffff, 16'hffff));
		drain_and_settle();
	endtask

	task automatic test_code_mapping();
		send_char(mk(8'd31, $urandom, $urandom, 1'b1, 16'd200, 16'd40));
		send_char(mk(CODE_FIRST, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		send_char(mk(8'd126, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		send_char(mk(8'd128, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		send_char(mk(8'h09, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		send_char(mk(CODE_SUBST, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		drain_and_settle();
	endtask

	task automatic test_clip_cases();
		// partial window, then a neighbour catching a single column
		apply_window(16'd104, 16'd52, 15'd5, 15'd3, 16'd4096, 32'h0);
		send_char(mk(8'h4d, $urandom, $urandom, 1'b1, 16'd100, 16'd50));
		send_char(mk(8'h57, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		drain_and_settle();
		apply_window(16'd0, 16'd0, 15'd0, 15'd768, 16'd4096, 32'h0);
		send_char(mk(8'h23, $urandom, $urandom, 1'b1, 16'd100, 16'd50));
		drain_and_settle();
		apply_window(16'd0, 16'd0, 15'd1024, 15'd0, 16'd4096, 32'h0);
		send_char(mk(8'h23, $urandom, $urandom, 1'b1, 16'd100, 16'd50));
		drain_and_settle();
		// fully clipped glyph must still move the cursor
		apply_window(16'd2000, 16'd0, 15'd64, 15'd768, 16'd4096, 32'h0);
		send_char(mk(8'h40, $urandom, $urandom, 1'b1, 16'd100, 16'd50));
		drain_and_settle();
		apply_window(16'd0, 16'd0, 15'd1024, 15'd768, 16'd4096, 32'h0);
		send_char(mk(8'h26, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		drain_and_settle();
	endtask

	task automatic test_wrap_and_address();
		apply_window(16'h7ff8, 16'h8000, 15'h7fff, 15'h7fff, 16'hffff, 32'hffff_ffff);
		send_char(mk(CODE_LAST, $urandom, $urandom, 1'b1, 16'h7ffc, 16'h8000));
		send_char(mk(CODE_LAST, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		drain_and_settle();
		apply_window(16'h8000, 16'h7fff, 15'h7fff, 15'h7fff, 16'h0, 32'h0);
		send_char(mk(8'h42, 32'hffff_ffff, 32'h0, 1'b1, 16'h7ffc, 16'h7fff));
		send_char(mk(CODE_NEWLINE, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		send_char(mk(8'h42, $urandom, $urandom, 1'b0, 16'h0, 16'h0));
		drain_and_settle();
		apply_window(16'd0, 16'd0, 15'd1024, 15'd768, 16'd4096, 32'h0);
	endtask

	task automatic random_window();
		int mode;
		mode = $urandom_range(0, 5);
		if (mode == 0) begin
			apply_window(16'd0, 16'd0, 15'd1024, 15'd768, $urandom, $urandom);
		end else if (mode == 1) begin
			apply_window(16'h7fff - $urandom_range(0, 40), $urandom, $urandom, $urandom,
				$urandom_range(0, 1) ? 16'hffff : 16'h0, $urandom);
		end else begin
			apply_window($urandom_range(0, 600) - 300, $urandom_range(0, 400) - 200,
				$urandom_range(0, 64), $urandom_range(0, 24), $urandom, $urandom);
		end
	endtask

	task automatic random_batch(input int count);
		int sent, len, k, pick;
		logic [7:0] code;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				send_char(mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
				sent++;
			end else begin
				len = $urandom_range(3, 9);
				for (k = 0; k < len && sent < count; k++) begin
					pick = $urandom_range(15);
					if (k > 0 && pick < 2) begin
						code = CODE_NEWLINE;
					end else if (k > 0 && pick == 2) begin
						code = $urandom;
					end else begin
						code = $urandom_range(CODE_FIRST, CODE_LAST);
					end
					send_char(mk(code, $urandom, $urandom, k == 0,
						win_left + $urandom_range(0, 80) - 24,
						win_top + $urandom_range(0, 30) - 12));
					sent++;
				end
			end
		end
	endtask

	task automatic test_random_text();
		int phase, batch;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			for (batch = 0; batch < 4; batch++) begin
				drain_and_settle();
				random_window();
				random_batch(20);
			end
		end
	endtask

	always @(negedge clk) begin
		pixel_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pixel_valid && !pixel_stall) begin
			if (pixels_due.size() == 0) begin
				note_mismatch($sformatf("unexpected pixel x=%0d y=%0d colour=%h addr=%h last=%b",
					pixel_x, pixel_y, pixel_colour, pixel_address, last_of_char));
			end else begin
				head_pixel = pixels_due.pop_front();
				pixels_checked++;
				if (head_pixel.x !== pixel_x || head_pixel.y !== pixel_y ||
						head_pixel.colour !== pixel_colour ||
						head_pixel.address !== pixel_address ||
						head_pixel.last !== last_of_char) begin
					note_mismatch($sformatf(
						"exp x=%0d y=%0d colour=%h addr=%h last=%b, got x=%0d y=%0d colour=%h addr=%h last=%b",
						$signed(head_pixel.x), $signed(head_pixel.y), head_pixel.colour,
						head_pixel.address, head_pixel.last, pixel_x, pixel_y, pixel_colour,
						pixel_address, last_of_char));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_write || (char_valid && !char_stall) || (pixel_valid && !pixel_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("watchdog: no request or pixel for %0d cycles", QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_CLIP_LEFT;
		cfg_data = '0;
		char_valid = 1'b0;
		char_code = '0;
		fg_colour = '0;
		bg_colour = '0;
		new_string = 1'b0;
		start_x = '0;
		start_y = '0;
		pixel_stall = 1'b0;
		win_left = '0;
		win_top = '0;
		win_w = 15'd1024;
		win_h = 15'd768;
		pitch = 16'd4096;
		fb_base = '0;
		cur_col = '0;
		cur_row = '0;
		margin_col = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_cursor();
		test_code_mapping();
		test_clip_cases();
		test_wrap_and_address();
		test_random_text();

		drain_and_settle();
		if (pixels_due.size() != 0) begin
			note_mismatch($sformatf("%0d pixel writes never arrived", pixels_due.size()));
		end
		$display("covered %0d characters, %0d pixel writes checked, %0d register settings",
			chars_sent, pixels_checked, settings_used);
		$display("idling: none, sender 85%%, receiver 85%%, both 34%%; %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
